// ===== rtl/doxv_pkg.sv =====
// Package for the dual oxygen cell valve control: widths, codes, reset values and state type.
`timescale 1ns / 1ps
package doxv_pkg;

  localparam int unsigned DoxvWindow = 40;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned CalW      = 15;
  localparam int unsigned MaskW     = 2;
  localparam int unsigned DelayW    = 16;
  localparam int unsigned SetpointW = 6;
  localparam int unsigned MeanW     = 16;
  localparam int unsigned OxyW      = 10;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned AirW      = 8;

  localparam logic [OxyW-1:0]   O2Cap     = 10'd999;
  localparam logic [AirW-1:0]   AirTenths = 8'd209;

  localparam logic [CalW-1:0]   FloorRst   = 15'd112;
  localparam logic [CalW-1:0]   CeilingRst = 15'd320;
  localparam logic [DelayW-1:0] DelayRst   = 16'd300;

  localparam int unsigned DefSumW      = SampleW + $clog2(DoxvWindow);
  localparam int unsigned DefFillW     = $clog2(DoxvWindow + 1);
  localparam int unsigned DefDividendW = DefSumW + AirW;
  localparam int unsigned DefDivisorW  = DefFillW + CalW;
  localparam int unsigned DefCountW    = $clog2(DefDividendW + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgCalOne   = 3'd0,
    CfgCalTwo   = 3'd1,
    CfgFloor    = 3'd2,
    CfgCeiling  = 3'd3,
    CfgMask     = 3'd4,
    CfgDelay    = 3'd5
  } cfg_index_e;

  typedef enum logic [0:0] {
    OpSample = 1'b0,
    OpTick   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StSum,
    StPrep,
    StMean,
    StOxy,
    StComb,
    StDone
  } state_e;

endpackage

// ===== rtl/doxv_sdiv.sv =====
// Bit-serial restoring divider that produces one quotient bit per cycle while busy.
`timescale 1ns / 1ps
module doxv_sdiv import doxv_pkg::*; #(
  parameter int unsigned DividendW = DefDividendW,
  parameter int unsigned DivisorW  = DefDivisorW,
  parameter int unsigned CountW    = DefCountW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [CountW-1:0]    steps_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o,
  output logic [DivisorW-1:0]  remainder_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [CountW-1:0]    cnt_q;
  logic [DividendW-1:0] dvd_q;
  logic [DivisorW-1:0]  dvs_q;
  logic [DivisorW-1:0]  rem_q;
  logic [DivisorW:0]    trial;
  logic                 ge;
  logic [DivisorW:0]    diff;

  assign trial = {rem_q, dvd_q[DividendW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CountW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CountW'(1);
        if (cnt_q == CountW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DividendW-2:0], ge};
      rem_q <= ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && dvs_q != '0) |-> (rem_q < dvs_q))
    else $error("partial remainder not below divisor");

endmodule

// ===== rtl/dual_oxygen_cell_valve_control.sv =====
// Top level of the dual oxygen cell valve control: window sums, cell evaluation and valve timer.
// A tick beat goes from acceptance straight to the done state. A sample beat passes through
// the sum, prep, mean, oxygen and combine states; the two bit-serial restoring dividers,
// one per cell, each first form the window mean one bit a cycle and then the oxygen quotient
// of 209*|sum| over fill*calibration.
// The window lives in one memory, read in the accepting cycle and written in the cycle after it.
// A result waits in an output register while the next beat is accepted.
`timescale 1ns / 1ps
module dual_oxygen_cell_valve_control import doxv_pkg::*; #(
  parameter int unsigned Window = DoxvWindow
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic signed [SampleW-1:0] sample_one_i,
  input  logic signed [SampleW-1:0] sample_two_i,
  input  logic [SetpointW-1:0] setpoint_percent_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [MeanW-1:0]     mean_one_o,
  output logic [MeanW-1:0]     mean_two_o,
  output logic [OxyW-1:0]      oxygen_one_o,
  output logic [OxyW-1:0]      oxygen_two_o,
  output logic                 warn_one_o,
  output logic                 warn_two_o,
  output logic [OxyW-1:0]      oxygen_combined_o,
  output logic                 reading_error_o,
  output logic                 valve_open_o
);

  localparam int unsigned FillW = $clog2(Window + 1);
  localparam int unsigned SlotW = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned SumW  = SampleW + $clog2(Window);
  localparam int unsigned DvdW  = SumW + AirW;
  localparam int unsigned DvW   = FillW + CalW;
  localparam int unsigned CntW  = $clog2(DvdW + 1);
  localparam logic [FillW-1:0] FillFull = FillW'(Window);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(Window - 1);

  state_e state_q, state_d;

  logic [CalW-1:0]   cal1_q, cal2_q, floor_q, ceil_q;
  logic [MaskW-1:0]  mask_q;
  logic [DelayW-1:0] delay_q;

  logic                  op_q;
  logic [SetpointW-1:0]  sp_q;
  logic signed [SampleW-1:0] s1_q, s2_q;

  logic [2*SampleW-1:0] win_mem [Window];
  logic [2*SampleW-1:0] rd_q;

  logic signed [SumW-1:0] sum1_q, sum2_q;
  logic [FillW-1:0] fill_q;
  logic [SlotW-1:0] slot_q;
  logic [DvdW-1:0]  x1_q, x2_q;
  logic [DvW-1:0]   ncal1_q, ncal2_q;

  logic [MeanW-1:0] mean1_q, mean2_q;
  logic [OxyW-1:0]  oxy1_q, oxy2_q;
  logic             warn1_q, warn2_q;
  logic [OxyW-1:0]  comb_q;
  logic             err_q;
  logic             valve_q;
  logic [DelayW-1:0] since_q;

  logic             out_valid_q;
  logic [MeanW-1:0] o_mean1_q, o_mean2_q;
  logic [OxyW-1:0]  o_oxy1_q, o_oxy2_q, o_comb_q;
  logic             o_warn1_q, o_warn2_q, o_err_q, o_valve_q;

  logic in_fire, mem_we, div_start, out_load, full;
  logic signed [SumW-1:0] sum1_d, sum2_d;
  logic [SumW-1:0] mag1, mag2;
  logic [CntW-1:0]  div_steps;
  logic [DvdW-1:0]  dvd1, dvd2, q1, q2;
  logic [DvW-1:0]   dvs1, dvs2, r1, r2;
  logic             done1, done2, div_done;
  logic             ok1, ok2, use1, use2;
  logic [OxyW:0]    total;
  logic [DelayW-1:0] since_inc;
  logic [OxyW-1:0]  sp_tenths;
  logic             open_req, valve_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = (op_i == OpTick) ? StDone : StSum;
        end
      end
      StSum:  state_d = StPrep;
      StPrep: state_d = StMean;
      StMean: begin
        if (div_done) state_d = StOxy;
      end
      StOxy: begin
        if (div_done) state_d = StComb;
      end
      StComb: state_d = StDone;
      StDone: begin
        if (!out_valid_q || out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      StIdle: in_ready_o = 1'b1;
      StSum:  mem_we     = 1'b1;
      StPrep: div_start  = 1'b1;
      StMean: div_start  = div_done;
      StDone: out_load   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal1_q  <= '0;
      cal2_q  <= '0;
      floor_q <= FloorRst;
      ceil_q  <= CeilingRst;
      mask_q  <= '0;
      delay_q <= DelayRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCalOne:  cal1_q  <= cfg_data_i[CalW-1:0];
        CfgCalTwo:  cal2_q  <= cfg_data_i[CalW-1:0];
        CfgFloor:   floor_q <= cfg_data_i[CalW-1:0];
        CfgCeiling: ceil_q  <= cfg_data_i[CalW-1:0];
        CfgMask:    mask_q  <= cfg_data_i[MaskW-1:0];
        CfgDelay:   delay_q <= cfg_data_i[DelayW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= op_i;
      sp_q <= setpoint_percent_i;
      s1_q <= sample_one_i;
      s2_q <= sample_two_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[slot_q] <= {s2_q, s1_q};
    end
    rd_q <= win_mem[slot_q];
  end

  assign full   = fill_q == FillFull;
  assign sum1_d = sum1_q + SumW'(s1_q)
                - (full ? SumW'($signed(rd_q[SampleW-1:0])) : SumW'(0));
  assign sum2_d = sum2_q + SumW'(s2_q)
                - (full ? SumW'($signed(rd_q[2*SampleW-1:SampleW])) : SumW'(0));

  assign mag1 = sum1_q[SumW-1] ? $unsigned(-sum1_q) : $unsigned(sum1_q);
  assign mag2 = sum2_q[SumW-1] ? $unsigned(-sum2_q) : $unsigned(sum2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum1_q <= '0;
      sum2_q <= '0;
      fill_q <= '0;
      slot_q <= '0;
    end else if (mem_we) begin
      sum1_q <= sum1_d;
      sum2_q <= sum2_d;
      if (!full) fill_q <= fill_q + FillW'(1);
      slot_q <= (slot_q == SlotLast) ? '0 : slot_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StPrep) begin
      x1_q    <= DvdW'(mag1) * DvdW'(AirTenths);
      x2_q    <= DvdW'(mag2) * DvdW'(AirTenths);
      ncal1_q <= DvW'(fill_q) * DvW'(cal1_q);
      ncal2_q <= DvW'(fill_q) * DvW'(cal2_q);
    end
  end

  // The mean pass consumes only the magnitude bits of a left-aligned dividend.
  always_comb begin
    if (state_q == StPrep) begin
      dvd1      = {mag1, AirW'(0)};
      dvd2      = {mag2, AirW'(0)};
      dvs1      = DvW'(fill_q);
      dvs2      = DvW'(fill_q);
      div_steps = CntW'(SumW);
    end else begin
      dvd1      = x1_q;
      dvd2      = x2_q;
      dvs1      = ncal1_q;
      dvs2      = ncal2_q;
      div_steps = CntW'(DvdW);
    end
  end

  doxv_sdiv #(
    .DividendW (DvdW),
    .DivisorW  (DvW),
    .CountW    (CntW)
  ) u_div_one (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .steps_i     (div_steps),
    .dividend_i  (dvd1),
    .divisor_i   (dvs1),
    .done_o      (done1),
    .quotient_o  (q1),
    .remainder_o (r1)
  );

  doxv_sdiv #(
    .DividendW (DvdW),
    .DivisorW  (DvW),
    .CountW    (CntW)
  ) u_div_two (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .steps_i     (div_steps),
    .dividend_i  (dvd2),
    .divisor_i   (dvs2),
    .done_o      (done2),
    .quotient_o  (q2),
    .remainder_o (r2)
  );

  assign div_done = done1 && done2;

  // The sum lies strictly inside the window times the fill exactly when the floored
  // mean and its remainder do.
  assign ok1 = (cal1_q > floor_q) && (cal1_q < ceil_q)
            && ((q1 > DvdW'(floor_q)) || ((q1 == DvdW'(floor_q)) && (r1 != '0)))
            && (q1 < DvdW'(ceil_q));
  assign ok2 = (cal2_q > floor_q) && (cal2_q < ceil_q)
            && ((q2 > DvdW'(floor_q)) || ((q2 == DvdW'(floor_q)) && (r2 != '0)))
            && (q2 < DvdW'(ceil_q));

  assign use1  = !warn1_q && !mask_q[0];
  assign use2  = !warn2_q && !mask_q[1];
  assign total = (use1 ? {1'b0, oxy1_q} : '0) + (use2 ? {1'b0, oxy2_q} : '0);

  // A zero calibration gives a zero divisor, whose all-ones quotient is capped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean1_q <= '0;
      mean2_q <= '0;
      warn1_q <= 1'b0;
      warn2_q <= 1'b0;
      oxy1_q  <= '0;
      oxy2_q  <= '0;
      comb_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      if (state_q == StMean && div_done) begin
        mean1_q <= q1[MeanW-1:0];
        mean2_q <= q2[MeanW-1:0];
        warn1_q <= !ok1;
        warn2_q <= !ok2;
      end
      if (state_q == StOxy && div_done) begin
        oxy1_q <= (q1 > DvdW'(O2Cap)) ? O2Cap : q1[OxyW-1:0];
        oxy2_q <= (q2 > DvdW'(O2Cap)) ? O2Cap : q2[OxyW-1:0];
      end
      if (state_q == StComb) begin
        err_q  <= !use1 && !use2;
        comb_q <= (use1 && use2) ? total[OxyW:1] : total[OxyW-1:0];
      end
    end
  end

  assign since_inc = (op_q == OpTick && since_q != '1) ? since_q + DelayW'(1) : since_q;
  assign sp_tenths = {1'b0, sp_q, 3'b000} + {3'b000, sp_q, 1'b0};
  assign open_req  = !err_q && (comb_q < sp_tenths);
  assign valve_d   = open_req ? 1'b1 : ((valve_q && since_inc > delay_q) ? 1'b0 : valve_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valve_q     <= 1'b0;
      since_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        valve_q <= valve_d;
        since_q <= open_req ? '0 : since_inc;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_mean1_q <= mean1_q;
      o_mean2_q <= mean2_q;
      o_oxy1_q  <= oxy1_q;
      o_oxy2_q  <= oxy2_q;
      o_warn1_q <= warn1_q;
      o_warn2_q <= warn2_q;
      o_comb_q  <= comb_q;
      o_err_q   <= err_q;
      o_valve_q <= valve_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign mean_one_o        = o_mean1_q;
  assign mean_two_o        = o_mean2_q;
  assign oxygen_one_o      = o_oxy1_q;
  assign oxygen_two_o      = o_oxy2_q;
  assign warn_one_o        = o_warn1_q;
  assign warn_two_o        = o_warn2_q;
  assign oxygen_combined_o = o_comb_q;
  assign reading_error_o   = o_err_q;
  assign valve_open_o      = o_valve_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("fill count beyond the window depth");

  a_slot_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != FillFull) |-> (FillW'(slot_q) == fill_q))
    else $error("write slot out of step with fill count while filling");

  a_open_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valve_q) |-> (since_q == '0))
    else $error("valve opened without clearing the close timer");

  a_sum_only_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSum) |-> (op_q == OpSample))
    else $error("window updated by a tick beat");

endmodule
